// ===== hdl/bsmh_pkg.sv =====
// ----------------------------------------------------------------------------
// bsmh_pkg: shared types and constants for the byte stream Mersenne hash
// Word formats of the input, internal and result queues, and the hash
// constants used by the datapath.
// ----------------------------------------------------------------------------
package bsmh_pkg;

  localparam logic [30:0] HASH_INIT  = 31'h7eadbeef;
  localparam logic [30:0] HASH_MOD   = 31'h7fffffff;
  localparam logic [15:0] POWER_BASE = 16'd31;
  localparam logic [15:0] POWER_INIT = 16'd1;

  localparam int QDEPTH_DEF = 2;
  localparam int ODEPTH_DEF = 2;

  typedef struct packed {
    logic signed [7:0] data_byte;
    logic              last_byte;
  } in_word_t;

  // Classified word handed from the front end to the hash engine.
  typedef struct packed {
    logic       neg;
    logic [7:0] bits;
    logic       last;
  } qword_t;

  typedef struct packed {
    logic [30:0] hash_value;
    logic        string_done;
  } out_word_t;

endpackage

// ===== hdl/bsmh_fifo.sv =====
// ----------------------------------------------------------------------------
// bsmh_fifo: small register queue
// First-in first-out buffer of DEPTH words with push/full and pop/empty.
// The head word is presented combinationally on rdata.
// ----------------------------------------------------------------------------
module bsmh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/bsmh_front.sv =====
// ----------------------------------------------------------------------------
// bsmh_front: input stage of the hash core
// Accepts input words into a register, classifies the character by sign
// and forwards the classified word into the work queue.
// ----------------------------------------------------------------------------
module bsmh_front import bsmh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_word_t in_data,
  output logic     in_full,
  output logic     q_push,
  output qword_t   q_data,
  input  logic     q_full
);

  logic   valid_r, valid_nxt;
  qword_t word_r, word_nxt;
  logic   accept;

  // The holding register frees up in the same cycle it drains into the queue.
  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_data  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (accept) begin
      valid_nxt     = 1'b1;
      word_nxt.neg  = in_data.data_byte[7];
      word_nxt.bits = in_data.data_byte;
      word_nxt.last = in_data.last_byte;
    end else if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ===== hdl/bsmh_back.sv =====
// ----------------------------------------------------------------------------
// bsmh_back: hash engine
// Holds the running hash and power term, folds one character per cycle
// while the result queue has room and pushes the running hash into that queue.
// ----------------------------------------------------------------------------
module bsmh_back import bsmh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  qword_t    q_data,
  output logic      q_pop,
  input  logic      o_full,
  output logic      o_push,
  output out_word_t o_data
);

  logic [30:0] hash_r, hash_nxt;
  logic [15:0] power_r, power_nxt;
  logic        fire;
  logic [63:0] ext, sum, mixed;
  logic [31:0] prod, pw_prod, fold2;
  logic [32:0] fold1;
  logic [30:0] hash_new;

  assign fire   = !q_empty && !o_full;
  assign q_pop  = fire;
  assign o_push = fire;

  always_comb begin
    ext   = {{56{q_data.neg}}, q_data.bits};
    sum   = {33'd0, hash_r} + ext;
    prod  = sum[15:0] * power_r;
    mixed = {sum[63:16], 16'd0} + {32'd0, prod};
    // 2^31 is congruent to 1 modulo 2^31-1, so the 31-bit slices are summed.
    fold1 = {2'b00, mixed[30:0]} + {2'b00, mixed[61:31]} + {31'd0, mixed[63:62]};
    fold2 = {1'b0, fold1[30:0]} + {30'd0, fold1[32:31]};
    if (fold2 >= {1'b0, HASH_MOD}) begin
      hash_new = 31'(fold2 - {1'b0, HASH_MOD});
    end else begin
      hash_new = fold2[30:0];
    end
    pw_prod = power_r * POWER_BASE;

    hash_nxt  = hash_r;
    power_nxt = power_r;
    if (fire) begin
      if (q_data.last) begin
        hash_nxt  = HASH_INIT;
        power_nxt = POWER_INIT;
      end else begin
        hash_nxt  = hash_new;
        power_nxt = pw_prod[15:0];
      end
    end

    o_data.hash_value  = hash_new;
    o_data.string_done = q_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= HASH_INIT;
      power_r <= POWER_INIT;
    end else begin
      hash_r  <= hash_nxt;
      power_r <= power_nxt;
    end
  end

  // The running hash is always a fully reduced residue.
  a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    hash_r != HASH_MOD)
    else $error("running hash not reduced");

  // Powers of 31 modulo 2^16 are always odd.
  a_power_odd: assert property (@(posedge clk) disable iff (!rst_n)
    power_r[0])
    else $error("power term lost its odd parity");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_data.last |=> hash_r == HASH_INIT && power_r == POWER_INIT)
    else $error("state not restored after final character");

endmodule

// ===== hdl/byte_stream_mersenne_hash_core.sv =====
// ----------------------------------------------------------------------------
// byte_stream_mersenne_hash_core: streaming string hash modulo 2^31-1
// Usage:
//   Input channel: drive in_data (character and last-character flag) and
//   raise in_push; the word is taken at a clock edge where in_full is low.
//   Result channel: while out_empty is low the oldest result is on out_data;
//   raise out_pop to take it. Every input word gives exactly one result word
//   carrying the running hash; string_done marks the final hash of a string.
//   Throughput: one word per cycle while the result queue has room, set by the
//   hash engine, which adds, multiplies by the 16-bit power and folds modulo
//   2^31-1 in one step.
//   Reset (rst_n low, synchronous) empties both queues and loads the hash
//   with 0x7eadbeef and the power with 1. A word flagged as last restores
//   these values after its result is formed.
//   When the receiver stalls the result queue fills, the engine holds, the
//   work queue fills behind it and in_full finally rises; nothing is lost.
// ----------------------------------------------------------------------------
module byte_stream_mersenne_hash_core import bsmh_pkg::*; #(
  parameter int QDEPTH = QDEPTH_DEF,
  parameter int ODEPTH = ODEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_word_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_data
);

  logic      fq_push, fq_full, fq_empty, fq_pop;
  qword_t    fq_wdata, fq_rdata;
  logic      oq_push, oq_full;
  out_word_t oq_wdata;

  bsmh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_push  (fq_push),
    .q_data  (fq_wdata),
    .q_full  (fq_full)
  );

  bsmh_fifo #(
    .WIDTH ($bits(qword_t)),
    .DEPTH (QDEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  bsmh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fq_empty),
    .q_data  (fq_rdata),
    .q_pop   (fq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_data  (oq_wdata)
  );

  bsmh_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (ODEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule
